// File: sv/lgge_pkg.sv
// Shared types and constants for the life grid generation engine.
package lgge_pkg;

    // Default grid edge length, in rows and in columns.
    localparam int GRID_SIZE_DEF = 16;

    // Widths of the request fields.
    localparam int ROW_INDEX_W = 4;
    localparam int ROW_BITS_W  = 16;

    // Request kinds.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Neighbour counts of the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic                   mode;
        logic [ROW_INDEX_W-1:0] row_index;
        logic [ROW_BITS_W-1:0]  row_bits;
    } in_req_t;

    typedef struct packed {
        logic [ROW_INDEX_W-1:0] row_index_res;
        logic [ROW_BITS_W-1:0]  row_bits_res;
        logic                   last;
    } out_req_t;

endpackage

// File: sv/lgge_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lgge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // The read data holds its value while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: sv/life_grid_generation_engine_unit.sv
// Top level of the life grid generation engine: grid store, row window and sweep sequencer.
//
// This block holds a GRID_SIZE by GRID_SIZE grid of one-bit sites and advances it by
// Conway's rule B3/S23, with everything outside the grid counted as dead, so the edges
// do not wrap. A request with mode set to write loads one row (bit n is column n) and
// produces no result; a write to a row index at or beyond GRID_SIZE is ignored, and bits
// above column GRID_SIZE-1 are dropped. A request with mode set to step computes the next
// generation from the old grid only, stores it, and emits GRID_SIZE result requests in
// row order, the final one carrying last. The grid lives in a single RAM with one write
// and one registered read port; a sliding window of three rows (above, current, below)
// feeds one row-wide rule unit that produces a whole new row per cycle while results
// are taken. A step first primes the window from the RAM with rows 0 and 1, then one
// row leaves per cycle when results are taken as they appear, bounded by the single RAM
// read per row. Back-pressure on the result side stalls the sweep row by row. The block
// takes no new request until the sweep has issued its last row, but a finished result
// may still wait in the output register while the next request is accepted. After reset
// the grid reads as all dead at once: every row has a valid bit that reset clears, so
// there is no clearing pass.
module life_grid_generation_engine_unit #(
    parameter int GRID_SIZE = lgge_pkg::GRID_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lgge_pkg::in_req_t  in_req,
    output logic               out_valid,
    input  logic               out_ready,
    output lgge_pkg::out_req_t out_req
);

    import lgge_pkg::*;

    // Width of a row and of a row address.
    localparam int GW = GRID_SIZE;
    localparam int IW = $clog2(GRID_SIZE);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] row_reg;
    logic [GW-1:0] row_vld_reg;
    logic          rd_vld_reg;
    logic [GW-1:0] above_reg;
    logic [GW-1:0] here_reg;
    logic          out_valid_reg;
    out_req_t      out_req_reg;

    // RAM connections.
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [GW-1:0] wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [GW-1:0] rd_data;

    // Sweep control.
    logic          in_take;
    logic          advance;
    logic          final_row;
    logic [GW-1:0] rd_row;
    logic [GW-1:0] below;
    logic [GW-1:0] fresh;

    // Write request decoding. Both the index and the grid size are brought to eight bits,
    // which covers every legal grid size, before the range check.
    logic [7:0]         wr_idx_ext;
    logic               wr_in_range;
    logic [GW+15:0]     in_bits_ext;
    logic [GW+15:0]     fresh_ext;
    logic [IW+3:0]      row_ext;

    assign in_take     = in_valid && in_ready;
    assign wr_idx_ext  = {4'b0, in_req.row_index};
    assign wr_in_range = wr_idx_ext < 8'(GRID_SIZE);
    assign in_bits_ext = {{GW{1'b0}}, in_req.row_bits};

    // A row read from the RAM counts only if that row has been written since reset.
    assign rd_row    = rd_data & {GW{rd_vld_reg}};
    assign final_row = row_reg == IW'(GRID_SIZE - 1);
    assign below     = final_row ? '0 : rd_row;

    // The sweep moves on by one row whenever the output register is free or being emptied.
    assign advance = (state_reg == ST_SWEEP) && (!out_valid_reg || out_ready);

    // Rule unit: one lane per column, each counting its eight neighbours in the old rows.
    logic [GW+1:0] above_pad;
    logic [GW+1:0] here_pad;
    logic [GW+1:0] below_pad;

    assign above_pad = {1'b0, above_reg, 1'b0};
    assign here_pad  = {1'b0, here_reg, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    for (genvar c = 0; c < GW; c++)
    begin : g_lane
        logic [3:0] nbr;
        assign nbr = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                   + 4'(here_pad[c])                        + 4'(here_pad[c+2])
                   + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
        assign fresh[c] = (nbr == BIRTH_COUNT) || (here_pad[c+1] && nbr == SURVIVE_COUNT);
    end

    assign fresh_ext = {16'b0, fresh};
    assign row_ext   = {4'b0, row_reg};

    // RAM port selection: the sweep owns the write port while it runs, the input otherwise.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_reg;
        wr_data = fresh;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                wr_en   = in_take && (in_req.mode == MODE_WRITE) && wr_in_range;
                wr_addr = wr_idx_ext[IW-1:0];
                wr_data = in_bits_ext[GW-1:0];
                rd_en   = in_take && (in_req.mode == MODE_STEP);
                rd_addr = '0;
            end
            ST_PRIME:
            begin
                rd_en   = 1'b1;
                rd_addr = IW'(1);
            end
            ST_SWEEP:
            begin
                wr_en   = advance;
                // The read for the next below row, while there is one left to read.
                rd_en   = advance && (row_reg < IW'(GRID_SIZE - 2));
                rd_addr = IW'(row_reg + IW'(2));
            end
            default:
            begin
                wr_en = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && in_req.mode == MODE_STEP)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (advance && final_row)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            row_vld_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
            if (state_reg == ST_PRIME)
            begin
                row_reg <= '0;
            end
            else if (advance && !final_row)
            begin
                row_reg <= row_reg + IW'(1);
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Row window and output payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PRIME)
        begin
            above_reg <= '0;
            here_reg  <= rd_row;
        end
        else if (advance)
        begin
            above_reg <= here_reg;
            here_reg  <= below;
        end
        if (advance)
        begin
            out_req_reg.row_index_res <= row_ext[3:0];
            out_req_reg.row_bits_res  <= fresh_ext[15:0];
            out_req_reg.last          <= final_row;
        end
    end

    lgge_ram #(
        .WIDTH (GW),
        .DEPTH (GRID_SIZE)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

endmodule

// File: sv/lgge_checker.sv
// Port-level checks for the life grid generation engine, bound to its top level.
module lgge_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input lgge_pkg::in_req_t  in_req,
    input logic               out_valid,
    input logic               out_ready,
    input lgge_pkg::out_req_t out_req
);

    import lgge_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_req))
        else $error("result request changed while stalled");

    // Once a step is accepted the block stops taking requests.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_req.mode == MODE_STEP |=> !in_ready)
        else $error("request taken straight after a step");

    // A row write never produces a result by itself.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_req.mode == MODE_WRITE && !out_valid |=> !out_valid)
        else $error("result appeared after a row write");

    // While a generation is still being emitted, no request is taken.
    a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_req.last |-> !in_ready)
        else $error("request taken in the middle of a generation");

endmodule

bind life_grid_generation_engine_unit lgge_checker u_lgge_checker (.*);
